@@ rtl/msf_pkg.sv @@
// Package for the median outlier scan filter.
// Shared job control type and constants; no dependencies.
package msf_pkg;

   localparam int TAIL_BITS = 4;
   localparam logic [7:0] SIGMA_RESET = 8'd32;

   typedef struct packed {
      logic                 emit_main;
      logic                 full;
      logic                 last;
      logic [TAIL_BITS-1:0] tail;
   } job_ctl_type;

   localparam int JOB_CTL_BITS = $bits(job_ctl_type);

endpackage

@@ rtl/msf_front.sv @@
// Front end: sample history, scan position and job classification.
// Depends on msf_pkg.
module msf_front
   import msf_pkg::*;
#(
   parameter int HALF_WINDOW = 5,
   parameter int RANGE_BITS  = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [15:0]                                   req_tdata,
   input  logic                                          req_tuser,
   input  logic                                          req_tlast,
   output logic                                          job_push,
   input  logic                                          job_ready,
   output job_ctl_type                                   job_ctl,
   output logic [(2*HALF_WINDOW+1)*(RANGE_BITS+1)-1:0]   job_win
);

   localparam int HL = 2 * HALF_WINDOW;
   localparam int SB = RANGE_BITS + 1;
   localparam int PW = $clog2(HL + 1);

   logic [SB-1:0] hist_ff [HL];
   logic [SB-1:0] hist_in [HL];
   logic [PW-1:0] pos_ff, pos_in;
   logic [SB-1:0] cur;
   logic          accept;

   assign req_tready = job_ready;
   assign accept     = req_tvalid && req_tready;
   assign cur        = {req_tuser, RANGE_BITS'(req_tdata)};

   for (genvar i = 0; i < HL; i++) begin : g_pack
      assign job_win[i*SB +: SB] = hist_ff[i];
   end
   assign job_win[HL*SB +: SB] = cur;

   always_comb begin
      job_ctl.full      = (pos_ff == PW'(HL));
      job_ctl.emit_main = (pos_ff >= PW'(HALF_WINDOW));
      job_ctl.last      = req_tlast;
      if (!req_tlast) begin
         job_ctl.tail = '0;
      end else if (job_ctl.emit_main) begin
         job_ctl.tail = TAIL_BITS'(HALF_WINDOW);
      end else begin
         job_ctl.tail = TAIL_BITS'(pos_ff) + TAIL_BITS'(1);
      end
   end

   assign job_push = accept && (job_ctl.emit_main || req_tlast);

   always_comb begin
      hist_in = hist_ff;
      pos_in  = pos_ff;
      if (accept) begin
         if (req_tlast) begin
            pos_in = '0;
         end else begin
            for (int i = 0; i + 1 < HL; i++) begin
               hist_in[i] = hist_ff[i+1];
            end
            hist_in[HL-1] = cur;
            if (pos_ff < PW'(HL)) begin
               pos_in = pos_ff + PW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         for (int i = 0; i < HL; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         pos_ff  <= pos_in;
         hist_ff <= hist_in;
      end
   end

endmodule

@@ rtl/msf_fifo.sv @@
// Two-entry job queue between front and back end.
// Depends on msf_pkg only for the import convention.
module msf_fifo
   import msf_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wptr_ff, rptr_ff;
   logic [1:0]       cnt_ff, cnt_in;
   logic             wr, rd;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rptr_ff];
   assign wr       = wr_valid && wr_ready;
   assign rd       = rd_valid && rd_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (wr && !rd) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (rd && !wr) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (wr) begin
            wptr_ff <= !wptr_ff;
         end
         if (rd) begin
            rptr_ff <= !rptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 && !rd |=> cnt_ff == 2'd2) else $error("queue lost entry");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> wptr_ff == rptr_ff) else $error("queue pointers diverged");

endmodule

@@ rtl/msf_back.sv @@
// Back end: serial window scan (sums, median rank search), exact sigma test,
// result emission through an output register. Depends on msf_pkg.
module msf_back
   import msf_pkg::*;
#(
   parameter int HALF_WINDOW = 5,
   parameter int RANGE_BITS  = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          job_valid,
   output logic                                          job_pop,
   input  job_ctl_type                                   job_ctl,
   input  logic [(2*HALF_WINDOW+1)*(RANGE_BITS+1)-1:0]   job_win,
   input  logic [7:0]                                    sigma,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [15:0]                                   rsp_tdata,
   output logic                                          rsp_tuser,
   output logic                                          rsp_tlast
);

   localparam int NW   = 2 * HALF_WINDOW + 1;
   localparam int R    = RANGE_BITS;
   localparam int SB   = R + 1;
   localparam int IW   = $clog2(NW);
   localparam int CW   = $clog2(NW + 1);
   localparam int SUMW = R + CW;
   localparam int S2W  = 2 * SUMW;
   localparam int QW   = 2 * R + CW;
   localparam int NQW  = QW + CW;
   localparam int AW   = 2 * SUMW;
   localparam int DL   = (NQW + 1) / 2;
   localparam int DH   = NQW - DL;
   localparam int RW   = 16 + NQW;
   localparam int CMPW = (AW + 8 > RW) ? AW + 8 : RW;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001,
      ST_SCAN = 8'b00000010,
      ST_PROD = 8'b00000100,
      ST_SQR  = 8'b00001000,
      ST_MLO  = 8'b00010000,
      ST_MHI  = 8'b00100000,
      ST_CMP  = 8'b01000000,
      ST_EMIT = 8'b10000000
   } state_type;

   state_type             state_ff, state_in;
   logic [SB-1:0]         win_ff [NW];
   job_ctl_type           ctl_ff;
   logic [IW-1:0]         idx_ff;
   logic [SUMW-1:0]       sum_ff;
   logic [QW-1:0]         sq_ff;
   logic [R-1:0]          med_ff;
   logic [S2W-1:0]        s2_ff;
   logic [NQW-1:0]        nq_ff, d_ff;
   logic [SUMW-1:0]       diff_ff;
   logic [15:0]           m2_ff;
   logic [AW-1:0]         a_ff;
   logic [16+DL-1:0]      plo_ff;
   logic [16+DH-1:0]      phi_ff;
   logic                  rvalid_ff;
   logic                  main_pend_ff;
   logic [TAIL_BITS-1:0]  rem_ff;
   logic                  out_v_ff;
   logic [15:0]           out_d_ff;
   logic                  out_u_ff, out_l_ff;

   logic                  all_valid;
   logic [R-1:0]          v;
   logic [2*R-1:0]        vsq;
   logic [CW-1:0]         lt, le;
   logic [SUMW-1:0]       nx;
   logic [CMPW-1:0]       lhs, rhs;
   logic                  load_out;

   always_comb begin
      all_valid = 1'b1;
      for (int i = 0; i < NW; i++) begin
         all_valid = all_valid & job_win[i*SB + R];
      end
   end

   // rank of the current candidate against the whole window
   assign v   = win_ff[idx_ff][R-1:0];
   assign vsq = v * v;
   always_comb begin
      lt = '0;
      le = '0;
      for (int j = 0; j < NW; j++) begin
         lt = lt + CW'(win_ff[j][R-1:0] < v);
         le = le + CW'(win_ff[j][R-1:0] <= v);
      end
   end

   assign nx  = SUMW'(win_ff[HALF_WINDOW][R-1:0]) * SUMW'(NW);
   assign lhs = CMPW'(a_ff) << 8;
   assign rhs = (CMPW'(phi_ff) << DL) + CMPW'(plo_ff);

   assign job_pop  = (state_ff == ST_IDLE) && job_valid;
   assign load_out = (state_ff == ST_EMIT) && (!out_v_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               if (job_ctl.emit_main && job_ctl.full && all_valid) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff == IW'(NW - 1)) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD: state_in = ST_SQR;
         ST_SQR:  state_in = ST_MLO;
         ST_MLO:  state_in = ST_MHI;
         ST_MHI:  state_in = ST_CMP;
         ST_CMP:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (load_out && rem_ff == TAIL_BITS'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_v_ff     <= 1'b0;
         main_pend_ff <= 1'b0;
         rem_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
         if (job_pop) begin
            main_pend_ff <= job_ctl.emit_main;
            rem_ff       <= job_ctl.tail + TAIL_BITS'(job_ctl.emit_main);
         end else if (load_out) begin
            main_pend_ff <= 1'b0;
            rem_ff       <= rem_ff - TAIL_BITS'(1);
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      if (job_pop) begin
         for (int i = 0; i < NW; i++) begin
            win_ff[i] <= job_win[i*SB +: SB];
         end
         ctl_ff    <= job_ctl;
         idx_ff    <= '0;
         sum_ff    <= '0;
         sq_ff     <= '0;
         rvalid_ff <= 1'b0;
      end
      if (state_ff == ST_SCAN) begin
         sum_ff <= sum_ff + SUMW'(v);
         sq_ff  <= sq_ff + QW'(vsq);
         idx_ff <= idx_ff + IW'(1);
         if (lt <= CW'(HALF_WINDOW) && le > CW'(HALF_WINDOW)) begin
            med_ff <= v;
         end
      end
      if (state_ff == ST_PROD) begin
         s2_ff   <= S2W'(sum_ff) * S2W'(sum_ff);
         nq_ff   <= NQW'(sq_ff) * NQW'(NW);
         diff_ff <= (nx > sum_ff) ? nx - sum_ff : sum_ff - nx;
         m2_ff   <= 16'(sigma) * 16'(sigma);
      end
      if (state_ff == ST_SQR) begin
         a_ff <= AW'(diff_ff) * AW'(diff_ff);
         d_ff <= nq_ff - NQW'(s2_ff);
      end
      if (state_ff == ST_MLO) begin
         plo_ff <= (16+DL)'(m2_ff) * (16+DL)'(d_ff[DL-1:0]);
      end
      if (state_ff == ST_MHI) begin
         phi_ff <= (16+DH)'(m2_ff) * (16+DH)'(d_ff[NQW-1:DL]);
      end
      if (state_ff == ST_CMP) begin
         rvalid_ff <= (lhs <= rhs);
      end
      if (load_out) begin
         if (main_pend_ff && rvalid_ff) begin
            out_d_ff <= 16'(med_ff);
            out_u_ff <= 1'b1;
         end else begin
            out_d_ff <= '0;
            out_u_ff <= 1'b0;
         end
         out_l_ff <= ctl_ff.last && (rem_ff == TAIL_BITS'(1));
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tuser  = out_u_ff;
   assign rsp_tlast  = out_l_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0) else $error("invalid result not zero");
   a_scan_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> idx_ff <= IW'(NW - 1)) else $error("scan index overrun");
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> rem_ff != '0) else $error("emit with no results left");

endmodule

@@ rtl/median_outlier_scan_filter_top.sv @@
// Top level of the median outlier scan filter.
// Depends on msf_pkg, msf_front, msf_fifo and msf_back.
//
// Usage:
//   req_* carries one range sample per transaction: tdata = range_mm,
//   tuser = sample_valid, tlast = last sample of the scan.
//   rsp_* carries results: tdata = filtered_mm (0 when invalid),
//   tuser = result_valid, tlast = final result of the scan.
//   csr_* writes sigma_multiplier_q4 (4.4 fixed point); write only while idle.
// Results trail the input by HALF_WINDOW samples; the last sample of a scan
// flushes the remaining ones. Scan edges and short scans give invalid results.
// Processing: each job is loaded, then scanned serially over its window (one
// sample per cycle through the rank and sum unit), then passes the product,
// square, sigma multiply and compare steps before its results are emitted. Jobs
// with an edge result or an invalid sample in the window skip scan and compare.
// A two-entry job queue lets the front keep taking samples while the back
// end computes or rsp_tready is low; req_tready drops when the queue is full.
// Reset (synchronous) empties the queue and history and sets sigma to 2.0.
module median_outlier_scan_filter_top
   import msf_pkg::*;
#(
   parameter int HALF_WINDOW = 5,
   parameter int RANGE_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] range_mm
   input  logic        req_tuser,   // [0] sample_valid
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] filtered_mm
   output logic        rsp_tuser,   // [0] result_valid
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int WINW = (2 * HALF_WINDOW + 1) * (RANGE_BITS + 1);
   localparam int JW   = JOB_CTL_BITS + WINW;

   logic [7:0]      sigma_ff;
   logic            push, push_ready, pop, q_valid;
   job_ctl_type     f_ctl, b_ctl;
   logic [WINW-1:0] f_win, b_win;
   logic [JW-1:0]   q_data;

   // sigma register, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= SIGMA_RESET;
      end else if (csr_valid && csr_ready) begin
         sigma_ff <= csr_data;
      end
   end

   msf_front #(.HALF_WINDOW(HALF_WINDOW), .RANGE_BITS(RANGE_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .job_push   (push),
      .job_ready  (push_ready),
      .job_ctl    (f_ctl),
      .job_win    (f_win)
   );

   msf_fifo #(.WIDTH(JW)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push),
      .wr_ready (push_ready),
      .wr_data  ({f_ctl, f_win}),
      .rd_valid (q_valid),
      .rd_ready (pop),
      .rd_data  (q_data)
   );

   assign b_ctl = q_data[JW-1:WINW];
   assign b_win = q_data[WINW-1:0];

   msf_back #(.HALF_WINDOW(HALF_WINDOW), .RANGE_BITS(RANGE_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_valid),
      .job_pop    (pop),
      .job_ctl    (b_ctl),
      .job_win    (b_win),
      .sigma      (sigma_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ tb/median_outlier_scan_filter_top_tb.sv @@
// Testbench for the median outlier scan filter top level.
// Self-checking: a scoreboard class predicts median/outlier results per sample.
// Depends on msf_pkg and median_outlier_scan_filter_top.
module median_outlier_scan_filter_top_tb;
   import msf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF = 5;
   localparam int HIST = 2 * HALF;
   localparam int WIN  = HIST + 1;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [15:0] mm;
      logic        ok;
      logic        last;
   } scan_result_type;

   // Scoreboard: holds the filter history, the sigma setting, and pending results.
   class median_scoreboard;
      logic [16:0]     history[HIST];   // bit 16 = valid flag
      int unsigned     position;
      logic [7:0]      sigma_q4;
      scan_result_type pending[$];
      int              errors;
      int              checked;
      int              valid_seen;

      function void clear();
         foreach (history[i]) history[i] = '0;
         position = 0;
         sigma_q4 = SIGMA_RESET;
         pending.delete();
         errors = 0;
         checked = 0;
         valid_seen = 0;
      endfunction

      // Median and exact sigma test over history plus current sample.
      function bit window_median(logic [16:0] cur, output logic [15:0] med);
         logic [15:0]  v[WIN];
         logic [15:0]  t;
         logic [63:0]  s, q, nx, diff;
         logic [127:0] lhs, rhs;
         med = '0;
         s = 0;
         q = 0;
         for (int i = 0; i < WIN; i++) begin
            logic [16:0] e;
            e = (i < HIST) ? history[i] : cur;
            if (!e[16]) return 0;
            v[i] = e[15:0];
            s += v[i];
            q += 64'(v[i]) * v[i];
         end
         nx = WIN * 64'(v[HALF]);
         diff = (nx > s) ? nx - s : s - nx;
         lhs = 128'(diff * diff) << 8;
         rhs = 128'(64'(sigma_q4) * sigma_q4) * 128'(WIN * q - s * s);
         if (lhs > rhs) return 0;
         for (int i = 1; i < WIN; i++)
            for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
               t = v[j];
               v[j] = v[j-1];
               v[j-1] = t;
            end
         med = v[HALF];
         return 1;
      endfunction

      function void note_sample(logic [15:0] mm, logic ok, logic last);
         logic [16:0]     cur;
         logic [15:0]     med;
         bit              good;
         int              tail;
         scan_result_type r;
         cur = {ok, mm};
         good = 0;
         med = '0;
         if (position >= HIST) good = window_median(cur, med);
         if (position >= HALF) begin
            r.mm = good ? med : 16'd0;
            r.ok = good;
            r.last = 0;
            pending.push_back(r);
         end
         if (last) begin
            tail = (position >= HALF) ? HALF : position + 1;
            repeat (tail) pending.push_back('{mm: 0, ok: 0, last: 0});
            pending[pending.size()-1].last = 1;
            position = 0;
            return;
         end
         for (int i = 0; i < HIST - 1; i++) history[i] = history[i+1];
         history[HIST-1] = cur;
         if (position < HIST) position++;
      endfunction

      function void check_result(scan_result_type got);
         scan_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result mm=%0d ok=%0b last=%0b",
                     $realtime, got.mm, got.ok, got.last);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.ok) valid_seen++;
         if (got !== want) begin
            $display("%0t: mismatch expected mm=%0d ok=%0b last=%0b actual mm=%0d ok=%0b last=%0b",
                     $realtime, want.mm, want.ok, want.last, got.mm, got.ok, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0, req_tuser = 0, req_tlast = 0;
   logic [15:0] req_tdata = '0;
   logic        req_tready;
   logic        rsp_tvalid, rsp_tuser, rsp_tlast;
   logic [15:0] rsp_tdata;
   logic        rsp_tready = 0;
   logic        csr_valid = 0;
   logic [7:0]  csr_data = '0;
   logic        csr_ready;

   median_scoreboard board;
   int  send_idle_pct = 0;   // sender idle chance per cycle
   int  recv_idle_pct = 0;   // receiver stall chance per cycle
   bit  hold_off = 0;        // long receiver stall request
   int  cycles = 0;
   int  samples_sent = 0;
   int  scans_sent = 0;

   median_outlier_scan_filter_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL median_outlier_scan_filter_top");
         $finish;
      end
   end

   // Result side: sample at the rising edge, new tready at the falling edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result('{mm: rsp_tdata, ok: rsp_tuser, last: rsp_tlast});
   end

   always @(negedge clock) begin
      if (reset || hold_off) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // One sample transaction; tvalid stays high across back-to-back samples.
   task automatic send_sample(logic [15:0] mm, logic ok, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= mm;
      req_tuser  <= ok;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_sample(mm, ok, last);
      samples_sent++;
      if (last) scans_sent++;
      @(negedge clock);
   endtask

   task automatic pause_sender();
      req_tvalid <= 0;
      @(negedge clock);
   endtask

   // Wait for all expected results plus the block's pipeline drain.
   task automatic drain();
      pause_sender();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_sigma(logic [7:0] value);
      drain();
      csr_valid <= 1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.sigma_q4 = value;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // One scan of len samples around a base level; noise sets the spread, and
   // bad_pct gives the chance of an invalid sample.
   task automatic send_scan(int len, logic [15:0] level, int noise, int bad_pct);
      int v;
      for (int i = 0; i < len; i++) begin
         v = int'(level) + $urandom_range(2 * noise) - noise;
         if ($urandom_range(19) == 0) v = $urandom_range(16'hffff);  // spike
         if (v < 0) v = 0;
         if (v > 65535) v = 65535;
         send_sample(16'(v), $urandom_range(99) >= bad_pct, i == len - 1);
      end
   endtask

   task automatic random_phase(int scans);
      repeat (scans) begin
         int len;
         len = ($urandom_range(4) == 0) ? $urandom_range(1, HIST) : $urandom_range(WIN, 30);
         if ($urandom_range(9) == 0)
            send_scan(len, $urandom_range(16'hffff), 0, 0);
         else
            send_scan(len, $urandom_range(16'hffff), $urandom_range(2000), 4);
      end
   endtask

   initial begin
      board = new();
      board.clear();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: extremes, invalid in window, zero spread, short scans.
      for (int i = 0; i < 13; i++)
         send_sample((i % 2) ? 16'hffff : 16'h0000, 1, i == 12);
      send_scan(1, 16'd100, 0, 0);                          // single-sample scan
      for (int i = 0; i < HIST; i++) send_sample(16'd500, 1, i == HIST - 1); // short
      for (int i = 0; i < 12; i++) send_sample(16'd777, 1, i == 11);        // zero spread
      for (int i = 0; i < 14; i++)
         send_sample(16'd1000 + i, i != 3, i == 13);        // invalid sample

      write_sigma(8'd0);
      send_scan(15, 16'd3000, 5, 0);
      write_sigma(8'hff);
      send_scan(15, 16'd3000, 3000, 0);
      write_sigma(8'h10);

      // Random phases with the three idling mixes.
      send_idle_pct = 27; recv_idle_pct = 48;
      random_phase(3);
      write_sigma($urandom_range(8'hff));
      send_idle_pct = 48; recv_idle_pct = 27;
      random_phase(3);

      // Receiver holds off while the sender keeps pushing; input must stall.
      hold_off = 1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         send_scan(25, 16'd20000, 500, 0);
      join
      write_sigma(SIGMA_RESET);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(3);
      drain();

      $display("covered %0d samples in %0d scans, %0d results checked (%0d valid)",
               samples_sent, scans_sent, board.checked, board.valid_seen);
      if (board.errors == 0) $display("PASS median_outlier_scan_filter_top");
      else $display("FAIL median_outlier_scan_filter_top");
      $finish;
   end
endmodule
